// ----- design/bqur_pkg.sv -----
package bqur_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_WORD_WIDTH  = 32;

    // Capacity register
    localparam int           CAP_W     = 5;
    localparam logic [4:0]   CAP_RESET = 5'd16;

    // Command codes
    localparam int CMD_W = 3;
    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_ENQUEUE  = 3'd0;
    localparam cmd_t CMD_PUSH     = 3'd1;
    localparam cmd_t CMD_DEQUEUE  = 3'd2;
    localparam cmd_t CMD_PEEK     = 3'd3;
    localparam cmd_t CMD_CONTAINS = 3'd4;
    localparam cmd_t CMD_REMOVE   = 3'd5;
    localparam cmd_t CMD_IS_EMPTY = 3'd6;
    localparam cmd_t CMD_READ_ALL = 3'd7;

endpackage

// ----- design/bounded_queue_unique_remove.sv -----
// Channel   | Direction | Ports
// ----------+-----------+------------------------------------------------------------
// input     | in        | s_valid, s_ready, s_cmd, s_value_in, s_unique_only
// result    | out       | m_valid, m_ready, m_ok, m_value_out, m_is_empty_flag,
//           |           | m_entry_count, m_last_result
// config    | in        | cfg_we, cfg_wdata (capacity limit, written at once)
//
// Entries sit in a single-port-read, single-port-write memory in head-to-tail order.
// A small sequencer walks that memory one entry per cycle while the result channel is not
// stalled; the memory read port sets the rate. Enqueue and is-empty answer straight from
// idle, peek reads the head, and a search, dequeue, push front, removal or read all walks
// the held entries; the duplicate check puts a search ahead of an insertion.
// Reset (aresetn low, synchronous) empties the queue and sets the limit to 16. A stalled
// result transfer holds the sequencer; new input is taken only when the sequencer is idle.
module bounded_queue_unique_remove #(
    parameter int QUEUE_DEPTH = bqur_pkg::DEF_QUEUE_DEPTH,
    parameter int WORD_WIDTH  = bqur_pkg::DEF_WORD_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [bqur_pkg::CAP_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bqur_pkg::cmd_t                      s_cmd,
    input  logic [WORD_WIDTH-1:0]               s_value_in,
    input  logic                                s_unique_only,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_ok,
    output logic [WORD_WIDTH-1:0]               m_value_out,
    output logic                                m_is_empty_flag,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    m_entry_count,
    output logic                                m_last_result
);
    import bqur_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHDN   = 3'd2;
    localparam logic [2:0] S_SHUP   = 3'd3;
    localparam logic [2:0] S_HEAD   = 3'd4;
    localparam logic [2:0] S_DUMP   = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [WORD_WIDTH-1:0] entry_mem [QUEUE_DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;

    logic [2:0]            state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [WORD_WIDTH-1:0] vin_reg, vin_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      pidx_reg, pidx_next;
    logic                  pend_reg, pend_next;
    logic                  left_reg, left_next;
    logic                  ok_reg, ok_next;
    logic [WORD_WIDTH-1:0] val_reg, val_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [CAP_W-1:0]      cap_reg;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_ok_reg;
    logic [WORD_WIDTH-1:0] m_value_reg;
    logic                  m_empty_reg;
    logic [CNT_W-1:0]      m_count_reg;
    logic                  m_last_reg;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;

    logic                  out_free;
    logic                  out_load;
    logic                  out_ok;
    logic [WORD_WIDTH-1:0] out_val;
    logic                  out_empty;
    logic                  out_last;

    logic                  accept;
    logic                  tail_room;
    logic                  hit;
    logic                  scan_more;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign tail_room = (8'(fill_reg) < 8'(cap_reg)) && (fill_reg < DEPTH_C);
    assign hit       = pend_reg && (rd_data_reg == vin_reg);
    assign scan_more = (idx_reg < fill_reg);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        vin_next   = vin_reg;
        idx_next   = idx_reg;
        pidx_next  = pidx_reg;
        pend_next  = pend_reg;
        left_next  = left_reg;
        ok_next    = ok_reg;
        val_next   = val_reg;
        fill_next  = fill_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = fill_reg[AW-1:0];
        wr_data    = vin_reg;
        out_load   = 1'b0;
        out_ok     = ok_reg;
        out_val    = val_reg;
        out_empty  = (fill_reg == '0);
        out_last   = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next   = s_cmd;
                    vin_next   = s_value_in;
                    ok_next    = 1'b0;
                    val_next   = '0;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_EMIT;
                    case (s_cmd)
                        CMD_ENQUEUE: begin
                            if (tail_room) begin
                                if (s_unique_only) begin
                                    state_next = S_SEARCH;
                                end else begin
                                    // append at the tail
                                    wr_en     = 1'b1;
                                    wr_data   = s_value_in;
                                    fill_next = fill_reg + 1'b1;
                                    ok_next   = 1'b1;
                                end
                            end
                        end
                        CMD_PUSH: begin
                            if (fill_reg < DEPTH_C) begin
                                if (s_unique_only) begin
                                    state_next = S_SEARCH;
                                end else begin
                                    idx_next   = fill_reg - 1'b1;
                                    left_next  = (fill_reg != '0);
                                    state_next = S_SHUP;
                                end
                            end
                        end
                        CMD_DEQUEUE: begin
                            if (fill_reg != '0) begin
                                state_next = S_SHDN;
                            end
                        end
                        CMD_PEEK: begin
                            if (fill_reg != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_HEAD;
                            end
                        end
                        CMD_CONTAINS, CMD_REMOVE: begin
                            state_next = S_SEARCH;
                        end
                        CMD_IS_EMPTY: begin
                            ok_next = 1'b1;
                        end
                        CMD_READ_ALL: begin
                            if (fill_reg != '0) begin
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // Compare the entry read last cycle while reading the next one
            S_SEARCH: begin
                if (hit) begin
                    pend_next = 1'b0;
                    case (cmd_reg)
                        CMD_CONTAINS: begin
                            ok_next    = 1'b1;
                            state_next = S_EMIT;
                        end
                        CMD_REMOVE: begin
                            idx_next   = pidx_reg + 1'b1;
                            state_next = S_SHDN;
                        end
                        default: begin
                            ok_next    = 1'b0;
                            state_next = S_EMIT;
                        end
                    endcase
                end else if (scan_more) begin
                    rd_en     = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    case (cmd_reg)
                        CMD_ENQUEUE: begin
                            wr_en      = 1'b1;
                            fill_next  = fill_reg + 1'b1;
                            ok_next    = 1'b1;
                            state_next = S_EMIT;
                        end
                        CMD_PUSH: begin
                            idx_next   = fill_reg - 1'b1;
                            left_next  = (fill_reg != '0);
                            state_next = S_SHUP;
                        end
                        default: begin
                            ok_next    = 1'b0;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // Move entries one place toward the head; position 0 is the dequeued word
            S_SHDN: begin
                if (pend_reg) begin
                    if (pidx_reg == '0) begin
                        val_next = rd_data_reg;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(pidx_reg - 1'b1);
                        wr_data = rd_data_reg;
                    end
                end
                if (scan_more) begin
                    rd_en     = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        fill_next  = fill_reg - 1'b1;
                        ok_next    = 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end

            // Move entries one place toward the tail, from the tail down, then fill the head
            S_SHUP: begin
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(pidx_reg + 1'b1);
                    wr_data = rd_data_reg;
                end
                if (left_reg) begin
                    rd_en     = 1'b1;
                    pidx_next = idx_reg;
                    pend_next = 1'b1;
                    if (idx_reg == '0) begin
                        left_next = 1'b0;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        fill_next  = fill_reg + 1'b1;
                        ok_next    = 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end

            S_HEAD: begin
                val_next   = rd_data_reg;
                ok_next    = 1'b1;
                state_next = S_EMIT;
            end

            // Stream every entry; hold the read pipeline while the output is stalled
            S_DUMP: begin
                out_ok    = 1'b1;
                out_val   = rd_data_reg;
                out_empty = 1'b0;
                out_last  = ((pidx_reg + 1'b1) == fill_reg);
                if (pend_reg && out_free) begin
                    out_load = 1'b1;
                end
                if (!pend_reg || out_free) begin
                    if (scan_more) begin
                        rd_en     = 1'b1;
                        pidx_next = idx_reg;
                        idx_next  = idx_reg + 1'b1;
                        pend_next = 1'b1;
                    end else begin
                        pend_next = 1'b0;
                        if (!pend_reg) begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output handshake
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            cap_reg     <= CAP_RESET;
            pend_reg    <= 1'b0;
            left_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        vin_reg  <= vin_next;
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
        ok_reg   <= ok_next;
        val_reg  <= val_next;
        if (out_load) begin
            m_ok_reg    <= out_ok;
            m_value_reg <= out_val;
            m_empty_reg <= out_empty;
            m_count_reg <= fill_reg;
            m_last_reg  <= out_last;
        end
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_value_out     = m_value_reg;
    assign m_is_empty_flag = m_empty_reg;
    assign m_entry_count   = m_count_reg;
    assign m_last_result   = m_last_reg;

endmodule

// ----- tb/bounded_queue_unique_remove_test.sv -----
module bounded_queue_unique_remove_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bqur_pkg::*;

    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int WORD_W      = DEF_WORD_WIDTH;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_OPS   = 58;
    localparam int PRINT_LIMIT = 40;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct {
        cmd_t  cmd;
        word_t value;
        logic  uniq;
        logic  hold;   // wait for every outstanding result before sending
    } queue_op_t;

    typedef struct {
        logic             ok;
        word_t            value;
        logic             empty;
        logic [CNT_W-1:0] count;
        logic             last;
    } queue_result_t;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             cfg_we        = 1'b0;
    logic [CAP_W-1:0] cfg_wdata     = '0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    cmd_t             s_cmd         = CMD_ENQUEUE;
    word_t            s_value_in    = '0;
    logic             s_unique_only = 1'b0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic             m_ok;
    word_t            m_value_out;
    logic             m_is_empty_flag;
    logic [CNT_W-1:0] m_entry_count;
    logic             m_last_result;

    queue_op_t        pending_ops[$];
    queue_result_t    expected_results[$];
    word_t            mirror_words[$];
    logic [CAP_W-1:0] mirror_cap = CAP_RESET;

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int send_gap;
    int recv_stall;
    int mismatches;
    int results_seen;
    int quiet_cycles;

    word_t word_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                             32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_0007, 32'h1234_5678};

    bounded_queue_unique_remove u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_value_in      (s_value_in),
        .s_unique_only   (s_unique_only),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_value_out     (m_value_out),
        .m_is_empty_flag (m_is_empty_flag),
        .m_entry_count   (m_entry_count),
        .m_last_result   (m_last_result)
    );

    always #1 aclk = ~aclk;

    // Mostly short gaps, a few long ones
    function automatic int next_gap(bit enabled);
        int roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int find_word(word_t v);
        foreach (mirror_words[i])
            if (mirror_words[i] == v)
                return i;
        return -1;
    endfunction

    function automatic void push_result(logic ok, word_t value, logic last);
        queue_result_t r;
        r.ok    = ok;
        r.value = value;
        r.empty = (mirror_words.size() == 0);
        r.count = CNT_W'(mirror_words.size());
        r.last  = last;
        expected_results.push_back(r);
    endfunction

    // Apply one command to the mirror queue and queue up the results it yields
    function automatic void model_queue_op(queue_op_t op);
        int    pos;
        int    held;
        logic  ok;
        word_t head;
        ok   = 1'b0;
        head = '0;
        pos  = find_word(op.value);
        held = mirror_words.size();
        case (op.cmd)
            CMD_ENQUEUE: begin
                if (held < int'(mirror_cap) && held < DEPTH && !(op.uniq && pos >= 0)) begin
                    mirror_words.push_back(op.value);
                    ok = 1'b1;
                end
            end
            CMD_PUSH: begin
                if (held < DEPTH && !(op.uniq && pos >= 0)) begin
                    mirror_words.push_front(op.value);
                    ok = 1'b1;
                end
            end
            CMD_DEQUEUE: begin
                if (held > 0) begin
                    head = mirror_words.pop_front();
                    ok   = 1'b1;
                end
            end
            CMD_PEEK: begin
                if (held > 0) begin
                    head = mirror_words[0];
                    ok   = 1'b1;
                end
            end
            CMD_CONTAINS: ok = (pos >= 0);
            CMD_REMOVE: begin
                if (pos >= 0) begin
                    mirror_words.delete(pos);
                    ok = 1'b1;
                end
            end
            CMD_IS_EMPTY: ok = 1'b1;
            CMD_READ_ALL: begin
                // One result per entry, head to tail
                if (held > 0) begin
                    for (int i = 0; i < held; i++)
                        push_result(1'b1, mirror_words[i], i == held - 1);
                    return;
                end
            end
        endcase
        push_result(ok, head, 1'b1);
    endfunction

    // Pick a command weighted toward growing or shrinking the queue
    function automatic queue_op_t random_op(bit filling);
        queue_op_t op;
        int        roll;
        roll = $urandom_range(0, 99);
        if (filling)
            op.cmd = roll < 35 ? CMD_ENQUEUE  : roll < 60 ? CMD_PUSH     :
                     roll < 65 ? CMD_DEQUEUE  : roll < 70 ? CMD_PEEK     :
                     roll < 78 ? CMD_CONTAINS : roll < 86 ? CMD_REMOVE   :
                     roll < 90 ? CMD_IS_EMPTY : CMD_READ_ALL;
        else
            op.cmd = roll < 10 ? CMD_ENQUEUE  : roll < 18 ? CMD_PUSH     :
                     roll < 43 ? CMD_DEQUEUE  : roll < 50 ? CMD_PEEK     :
                     roll < 60 ? CMD_CONTAINS : roll < 80 ? CMD_REMOVE   :
                     roll < 88 ? CMD_IS_EMPTY : CMD_READ_ALL;
        // Reuse a small set of words so duplicates and hits are common
        op.value = ($urandom_range(0, 99) < 65) ? word_pool[$urandom_range(0, 7)] : $urandom();
        op.uniq  = 1'($urandom_range(0, 1));
        op.hold  = 1'b0;
        return op;
    endfunction

    task automatic report_mismatch(string field, word_t got, word_t want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch %0t ns, result %0d: %s got %h, want %h",
                     $time, results_seen, field, got, want);
        mismatches++;
    endtask

    task automatic add_op(cmd_t cmd, word_t value, logic uniq);
        queue_op_t op;
        op.cmd   = cmd;
        op.value = value;
        op.uniq  = uniq;
        op.hold  = 1'b0;
        pending_ops.push_back(op);
    endtask

    // Sample at the falling edge, once all rising-edge updates have settled
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_ops.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] limit);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        mirror_cap = limit;
    endtask

    // Drive the command channel from the pending list
    always @(posedge aclk) begin : drive_commands
        queue_op_t op;
        bit        slot_free;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            slot_free = !s_valid || s_ready;
            if (s_valid && s_ready) begin
                op.cmd   = s_cmd;
                op.value = s_value_in;
                op.uniq  = s_unique_only;
                op.hold  = 1'b0;
                model_queue_op(op);
                send_gap = next_gap(send_idle);
            end
            if (slot_free) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_ops.size() > 0 &&
                             !(pending_ops[0].hold && expected_results.size() > 0)) begin
                    op = pending_ops.pop_front();
                    s_valid       <= 1'b1;
                    s_cmd         <= op.cmd;
                    s_value_in    <= op.value;
                    s_unique_only <= op.uniq;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result transfer against the oldest prediction; stall at random
    always @(posedge aclk) begin : check_results
        queue_result_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing predicted", m_value_out, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_ok !== want.ok)
                        report_mismatch("ok", word_t'(m_ok), word_t'(want.ok));
                    if (m_value_out !== want.value)
                        report_mismatch("value_out", m_value_out, want.value);
                    if (m_is_empty_flag !== want.empty)
                        report_mismatch("is_empty_flag", word_t'(m_is_empty_flag),
                                        word_t'(want.empty));
                    if (m_entry_count !== want.count)
                        report_mismatch("entry_count", word_t'(m_entry_count),
                                        word_t'(want.count));
                    if (m_last_result !== want.last)
                        report_mismatch("last_result", word_t'(m_last_result),
                                        word_t'(want.last));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready    <= 1'b1;
                recv_stall = next_gap(recv_idle);
            end
        end
    end

    // Abort when no transfer happens for too long
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL bounded_queue_unique_remove");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int        limits [8];
        int        run_len;
        int        flip_in;
        bit        filling;
        queue_op_t op;

        limits = '{1, 0, 31, 16, 2, 15, 0, 8};
        limits[6] = $urandom_range(1, 16);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty queue: every read and search comes back not ok, is-empty comes back ok
        add_op(CMD_DEQUEUE,  32'h0000_0000, 1'b0);
        add_op(CMD_PEEK,     32'h0000_0000, 1'b0);
        add_op(CMD_READ_ALL, 32'h0000_0000, 1'b0);
        add_op(CMD_CONTAINS, 32'h0000_0000, 1'b1);
        add_op(CMD_REMOVE,   32'h0000_0000, 1'b0);
        add_op(CMD_IS_EMPTY, 32'h0000_0000, 1'b0);
        // Insert at both ends, with and without the duplicate check
        add_op(CMD_ENQUEUE,  32'h0000_0000, 1'b1);
        add_op(CMD_ENQUEUE,  32'hFFFF_FFFF, 1'b0);
        add_op(CMD_ENQUEUE,  32'h0000_0000, 1'b1);
        add_op(CMD_ENQUEUE,  32'h0000_0000, 1'b0);
        add_op(CMD_PUSH,     32'hA5A5_A5A5, 1'b1);
        add_op(CMD_PUSH,     32'hFFFF_FFFF, 1'b1);
        add_op(CMD_CONTAINS, 32'hFFFF_FFFF, 1'b0);
        add_op(CMD_CONTAINS, 32'h5A5A_5A5A, 1'b0);
        add_op(CMD_PEEK,     32'h0000_0000, 1'b0);
        add_op(CMD_READ_ALL, 32'h0000_0000, 1'b0);
        // Remove from the middle, then a miss, then drain past empty
        add_op(CMD_REMOVE,   32'h0000_0000, 1'b0);
        add_op(CMD_REMOVE,   32'h1234_5678, 1'b0);
        add_op(CMD_IS_EMPTY, 32'h0000_0000, 1'b0);
        add_op(CMD_DEQUEUE,  32'h0000_0000, 1'b0);
        add_op(CMD_DEQUEUE,  32'h0000_0000, 1'b0);
        add_op(CMD_DEQUEUE,  32'h0000_0000, 1'b0);
        add_op(CMD_DEQUEUE,  32'h0000_0000, 1'b0);
        add_op(CMD_IS_EMPTY, 32'h0000_0000, 1'b0);
        wait_drained();

        foreach (limits[p]) begin
            write_capacity(CAP_W'(limits[p]));
            send_idle = (p % 4 == 0) || (p % 4 == 2);
            recv_idle = (p % 4 == 0) || (p % 4 == 3);

            // Open with a burst of insertions, then alternate growing and shrinking
            run_len = $urandom_range(12, 22);
            filling = 1'b0;
            flip_in = $urandom_range(8, 20);
            for (int k = 0; k < PHASE_OPS; k++) begin
                if (k < run_len) begin
                    op.cmd   = (limits[p] < 2 || $urandom_range(0, 1)) ? CMD_PUSH : CMD_ENQUEUE;
                    op.value = $urandom();
                    op.uniq  = 1'($urandom_range(0, 1));
                end else begin
                    op = random_op(filling);
                    flip_in--;
                    if (flip_in == 0) begin
                        filling = !filling;
                        flip_in = $urandom_range(8, 20);
                    end
                end
                op.hold = (k == 30) || ($urandom_range(0, 39) == 0);
                pending_ops.push_back(op);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS bounded_queue_unique_remove");
        else
            $display("FAIL bounded_queue_unique_remove");
        $finish;
    end

endmodule
